>>> rtl/first_fit_contiguous_allocator_top_defines.svh
// Assertion macros for the first-fit contiguous allocator.
// Used by the top level; no other dependencies.
`ifndef FIRST_FIT_CONTIGUOUS_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_CONTIGUOUS_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, masked while reset is held
`define FFCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included
`define FFCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFCA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFCA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/ffca_pkg.sv
// Shared types and constants for the first-fit contiguous allocator.
// No dependencies.
`default_nettype none

package ffca_pkg;

    // Default number of storage blocks in the used map
    localparam int NUM_BLOCKS_DEF = 128;

    // Fixed field widths
    localparam int CFG_W   = 8;
    localparam int LEN_W   = 8;
    localparam int START_W = 7;

    // Reset value of the blocks-in-use register
    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/first_fit_contiguous_allocator_top.sv
// First-fit contiguous allocator: one bitmap RAM, scan then mark sequencer.
// Per request: accept, scan up to the limit, mark the granted run, then hand over the result.
// Requests are handled one at a time: a new one is taken only in the idle state; scan and mark
// go one block at a time through the single-bit read and write ports of the used-map RAM.
// Reset: synchronous, active low; afterwards a clearing pass over all NUM_BLOCKS entries empties the
// map and holds off requests (configuration writes are taken throughout).
`default_nettype none
`include "first_fit_contiguous_allocator_top_defines.svh"

module first_fit_contiguous_allocator_top
    import ffca_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [LEN_W-1:0]     i_request_length,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_granted,
    output logic [START_W-1:0]        o_run_start
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    // Used-map RAM
    logic r_mem [NUM_BLOCKS];
    logic r_rd_data;

    // Control and working registers
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_blocks_in_use;
    logic [LEN_W-1:0]    r_want, n_want;
    logic [CW-1:0]       r_limit, n_limit;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_rd_valid, n_rd_valid;
    logic [AW-1:0]       r_rd_idx, n_rd_idx;
    logic [LEN_W-1:0]    r_run, n_run;
    logic [AW-1:0]       r_first, n_first;
    logic [AW-1:0]       r_mark_addr, n_mark_addr;
    logic [LEN_W-1:0]    r_mark_cnt, n_mark_cnt;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic                r_found, n_found;
    logic                r_out_valid, n_out_valid;
    logic                r_granted, n_granted;
    logic [START_W-1:0]  r_start, n_start;

    logic                rd_en;
    logic                wr_en;
    logic                wr_data;
    logic [AW-1:0]       wr_addr;
    logic                in_xfer;
    logic                out_free;
    logic [LW-1:0]       cfg_ext;
    logic [CW-1:0]       limit_now;
    logic [AW-1:0]       hit_first;
    logic                hit;

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_granted;
    assign o_run_start   = r_start;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Saturate the configured count at the map size
    assign cfg_ext   = LW'(r_blocks_in_use);
    assign limit_now = (cfg_ext < LW'(NUM_BLOCKS)) ? CW'(cfg_ext) : CW'(NUM_BLOCKS);

    // Scan decision on the returned bit
    assign hit_first = (r_run == '0) ? r_rd_idx : r_first;
    assign hit       = r_rd_valid && !r_rd_data && ((r_run + LEN_W'(1)) == r_want);

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blocks_in_use <= i_cfg_data;
        end
    end

    // Used-map RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_want      <= n_want;
        r_limit     <= n_limit;
        r_addr      <= n_addr;
        r_rd_idx    <= n_rd_idx;
        r_run       <= n_run;
        r_first     <= n_first;
        r_mark_addr <= n_mark_addr;
        r_mark_cnt  <= n_mark_cnt;
        r_found     <= n_found;
        r_granted   <= n_granted;
        r_start     <= n_start;
    end

    // Sequencer: clear, accept, scan, mark, hand over the result
    always_comb begin
        n_state     = r_state;
        n_want      = r_want;
        n_limit     = r_limit;
        n_addr      = r_addr;
        n_rd_valid  = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_run       = r_run;
        n_first     = r_first;
        n_mark_addr = r_mark_addr;
        n_mark_cnt  = r_mark_cnt;
        n_clr_addr  = r_clr_addr;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_granted   = r_granted;
        n_start     = r_start;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_data     = 1'b0;
        wr_addr     = r_clr_addr;

        // Drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                wr_data    = 1'b0;
                wr_addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (CW'(r_clr_addr) == CW'(NUM_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_want  = i_request_length;
                    n_limit = limit_now;
                    n_addr  = '0;
                    n_run   = '0;
                    n_first = '0;
                    n_found = 1'b0;
                    if (i_request_length == '0 || limit_now == '0) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue the next read while the previous bit is checked
                if (r_addr < r_limit) begin
                    rd_en      = 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_addr[AW-1:0];
                    n_addr     = r_addr + CW'(1);
                end
                if (r_rd_valid) begin
                    if (r_rd_data) begin
                        n_run = '0;
                    end else begin
                        n_run   = r_run + LEN_W'(1);
                        n_first = hit_first;
                    end
                end
                if (hit) begin
                    n_rd_valid  = 1'b0;
                    n_found     = 1'b1;
                    n_mark_addr = hit_first;
                    n_mark_cnt  = r_want;
                    n_state     = S_MARK;
                end else if (r_rd_valid && r_addr == r_limit) begin
                    n_state = S_RESULT;
                end
            end
            S_MARK: begin
                wr_en       = 1'b1;
                wr_data     = 1'b1;
                wr_addr     = r_mark_addr;
                n_mark_addr = r_mark_addr + AW'(1);
                n_mark_cnt  = r_mark_cnt - LEN_W'(1);
                if (r_mark_cnt == LEN_W'(1)) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_granted   = r_found;
                    n_start     = r_found ? START_W'(r_first) : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks
    `FFCA_ASSERT(a_clear_stalls, i_clk, i_rst_n, r_state == S_CLEAR |-> o_in_stall, "clear")
    `FFCA_ASSERT(a_scan_in_range, i_clk, i_rst_n, rd_en |-> r_addr < r_limit, "read past limit")
    `FFCA_ASSERT(a_mark_nonzero, i_clk, i_rst_n, r_state == S_MARK |-> r_mark_cnt != '0, "mark")
    `FFCA_ASSERT(a_reject, i_clk, i_rst_n, r_out_valid && !r_granted |-> r_start == '0, "start")

endmodule

`default_nettype wire

>>> tb/first_fit_contiguous_allocator_top_test.sv
// Self-checking testbench for the first-fit contiguous block allocator.
// Depends on ffca_pkg and first_fit_contiguous_allocator_top; predicts every grant from
// its own copy of the used-block map and compares each result transfer in order.
`timescale 1ns / 1ps

module first_fit_contiguous_allocator_top_test;
    import ffca_pkg::*;

    localparam int BLOCKS       = NUM_BLOCKS_DEF;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 800;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] run_start;
    } alloc_result_t;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [LEN_W-1:0]   i_request_length = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_granted;
    logic [START_W-1:0] o_run_start;

    // Predictor state: used map and blocks-in-use register
    logic [BLOCKS-1:0]  used_map;
    logic [CFG_W-1:0]   blocks_cfg;
    alloc_result_t      pending_grants[$];
    int unsigned        mismatch_count = 0;

    // Idling controls for the sender and the receiver
    bit                 tx_idle_on = 1'b1;
    bit                 rx_idle_on = 1'b1;
    int unsigned        hold_request = 0;
    int unsigned        long_hold_left = 0;
    int unsigned        result_wait = 0;

    wire request_xfer = i_rst_n && i_in_valid && !o_in_stall;
    wire result_xfer  = i_rst_n && o_out_valid && !i_out_stall;
    wire cfg_xfer     = i_rst_n && i_cfg_valid && o_cfg_ready;

    first_fit_contiguous_allocator_top #(
        .NUM_BLOCKS(BLOCKS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_request_length (i_request_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_granted        (o_granted),
        .o_run_start      (o_run_start)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Find the lowest free run of the requested length and mark it used
    function automatic alloc_result_t first_fit_allocate(input logic [LEN_W-1:0] want);
        alloc_result_t res;
        int unsigned   limit;
        int unsigned   run;
        int unsigned   first;
        int unsigned   blk;
        res = '0;
        limit = (blocks_cfg < BLOCKS) ? blocks_cfg : BLOCKS;
        run = 0;
        first = 0;
        blk = 0;
        if (want != 0) begin
            while (blk < limit && !res.granted) begin
                if (!used_map[blk]) begin
                    if (run == 0)
                        first = blk;
                    run++;
                    if (run == want)
                        res.granted = 1'b1;
                end else begin
                    run = 0;
                end
                blk++;
            end
        end
        if (res.granted) begin
            for (blk = first; blk < first + want; blk++)
                used_map[blk] = 1'b1;
            res.run_start = first[START_W-1:0];
        end
        return res;
    endfunction

    // Mostly short runs, with zero, long and out-of-range lengths mixed in
    function automatic logic [LEN_W-1:0] draw_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        else if (pick < 70)
            return LEN_W'($urandom_range(1, 4));
        else if (pick < 85)
            return LEN_W'($urandom_range(5, 16));
        else if (pick < 93)
            return LEN_W'($urandom_range(17, 127));
        else
            return LEN_W'($urandom_range(128, 255));
    endfunction

    // Offer one request after a random gap; predict its result on transfer
    task automatic send_request(input logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_request_length <= len;
        do @(posedge i_clk); while (o_in_stall);
        pending_grants.push_back(first_fit_allocate(len));
    endtask

    // Drain outstanding results, then write blocks-in-use
    task automatic write_blocks_in_use(input logic [CFG_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        blocks_cfg = value;
    endtask

    // Zero length, oversized lengths, empty and saturated register, blocks past the limit
    task automatic test_directed();
        send_request(8'd0);
        send_request(8'd255);
        send_request(8'd129);
        send_request(8'd1);
        send_request(8'd128);
        write_blocks_in_use(8'd0);
        send_request(8'd1);
        send_request(8'd128);
        write_blocks_in_use(8'd3);
        send_request(8'd2);
        send_request(8'd1);
        write_blocks_in_use(8'd255);
        send_request(8'd2);
        send_request(8'd1);
        write_blocks_in_use(8'd1);
        send_request(8'd1);
        send_request(8'd0);
        write_blocks_in_use(8'd128);
        send_request(8'd4);
    endtask

    // Hold the result side off for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        tx_idle_on = 1'b0;
        @(negedge i_clk);
        hold_request = LONG_HOLD;
        @(posedge i_clk);
        repeat (6) send_request(draw_length());
        tx_idle_on = 1'b1;
    endtask

    // Pause the request side until every outstanding result has come back
    task automatic test_drain_pause();
        repeat (4) send_request(draw_length());
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) send_request(draw_length());
    endtask

    // Random phases over a spread of register settings and idling mixes
    task automatic test_random_phases();
        logic [CFG_W-1:0] phase_cfg;
        int unsigned      p;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_cfg = 8'd16;
                1:       phase_cfg = 8'd40;
                2:       phase_cfg = CFG_W'($urandom_range(1, 127));
                3:       phase_cfg = 8'd72;
                4:       phase_cfg = 8'd96;
                5:       phase_cfg = CFG_W'($urandom_range(0, 255));
                6:       phase_cfg = 8'd128;
                default: phase_cfg = 8'd255;
            endcase
            tx_idle_on = (p % 4 == 0) || (p % 4 == 2);
            rx_idle_on = (p % 4 == 0) || (p % 4 == 1);
            write_blocks_in_use(phase_cfg);
            repeat (PHASE_ITEMS) send_request(draw_length());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result side: random stall after each transfer, plus the long hold on request
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            long_hold_left = hold_request;
            hold_request = 0;
        end else if (long_hold_left != 0) begin
            long_hold_left--;
        end
        if (result_xfer)
            result_wait = rx_idle_on ? $urandom_range(0, 13) : 0;
        else if (result_wait != 0)
            result_wait--;
        i_out_stall <= (result_wait != 0) || (long_hold_left != 0);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        alloc_result_t want;
        if (result_xfer) begin
            if (pending_grants.size() == 0) begin
                $error("result with nothing pending: granted=%0d run_start=%0d",
                       o_granted, o_run_start);
                mismatch_count++;
            end else begin
                want = pending_grants.pop_front();
                if (o_granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, o_granted);
                    mismatch_count++;
                end
                if (o_run_start !== want.run_start) begin
                    $error("run_start: expected %0d, got %0d",
                           want.run_start, o_run_start);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort when no transfer of any kind has happened for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || request_xfer || result_xfer || cfg_xfer)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        used_map   = '0;
        blocks_cfg = CFG_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_result_backpressure();
        test_drain_pause();
        test_random_phases();
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_grants.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> first_fit_contiguous_allocator_top.f
+incdir+rtl
rtl/ffca_pkg.sv
rtl/first_fit_contiguous_allocator_top.sv
tb/first_fit_contiguous_allocator_top_test.sv
